// ===== design/mcs_pkg.sv =====
// Shared package of the mobility correction stencil.
// Holds field widths, parameter defaults, read-select codes and the
// controller/datapath command and status types. No dependencies.
package mcs_pkg;

    // Parameter defaults.
    localparam int unsigned DEF_GRID_SIDE     = 64;
    localparam int unsigned DEF_GRID_DIMS     = 2;
    localparam int unsigned DEF_SPECIES_COUNT = 4;
    localparam int unsigned DEF_FRACTION_BITS = 16;
    localparam int unsigned DEF_DEPTH         =
        DEF_GRID_SIDE * DEF_GRID_SIDE * DEF_SPECIES_COUNT;

    // Field widths.
    localparam int unsigned SP_W      = 2;
    localparam int unsigned CELL_W    = 12;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned INV_W     = 31;
    localparam int unsigned CFG_IDX_W = 1;

    // Arithmetic widths.
    localparam int unsigned DIFF_W = DATA_W + 1;   // difference of two values
    localparam int unsigned ACC_W  = 68;           // sum of up to four products
    localparam int unsigned LO_W   = 34;           // low slice of the sum
    localparam int unsigned MUL_W  = 35;           // shared multiplier operand
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned FULL_W = 100;          // sum times reciprocal

    // Request types.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MOB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX2 = 1'b1;

    // Read-select codes, in the order the controller issues them.
    localparam int unsigned SEL_W = 3;
    localparam logic [SEL_W-1:0] SEL_CENTER = 3'd0;
    localparam logic [SEL_W-1:0] SEL_XP     = 3'd1;
    localparam logic [SEL_W-1:0] SEL_XM     = 3'd2;
    localparam logic [SEL_W-1:0] SEL_YP     = 3'd3;
    localparam logic [SEL_W-1:0] SEL_YM     = 3'd4;

    typedef struct packed {
        logic             latch;
        logic             div1;
        logic             div2;
        logic             nbr;
        logic             wr_en;
        logic             rd_en;
        logic [SEL_W-1:0] rd_sel;
        logic             scale_lo;
        logic             scale_hi;
        logic             sum;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
    } t_dp_status;

endpackage

// ===== design/mcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Uses mcs_pkg for default sizes only.
module mcs_ram #(
    parameter int unsigned WIDTH = mcs_pkg::DATA_W,
    parameter int unsigned DEPTH = mcs_pkg::DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mcs_ctrl.sv =====
// Controller state machine of the mobility correction stencil.
// Depends on mcs_pkg for the command and status types.
module mcs_ctrl #(
    parameter int unsigned GRID_DIMS = mcs_pkg::DEF_GRID_DIMS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  mcs_pkg::t_dp_status i_status,
    output mcs_pkg::t_dp_cmd    o_cmd
);

    localparam int unsigned NREADS = 1 + 2 * GRID_DIMS;
    localparam logic [mcs_pkg::SEL_W-1:0] LAST_SEL   = mcs_pkg::SEL_W'(NREADS - 1);
    localparam logic [mcs_pkg::SEL_W-1:0] DRAIN_LAST = mcs_pkg::SEL_W'(2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV1  = 4'd1;
    localparam logic [3:0] S_DIV2  = 4'd2;
    localparam logic [3:0] S_NBR   = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_SC_LO = 4'd7;
    localparam logic [3:0] S_SC_HI = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]                r_state, n_state;
    logic [mcs_pkg::SEL_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div1 = 1'b1;
                n_state    = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div2 = 1'b1;
                n_state    = S_NBR;
            end
            S_NBR: begin
                o_cmd.nbr = 1'b1;
                n_cnt     = '0;
                n_state   = i_status.is_query ? S_READ : S_WR;
            end
            S_WR: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_IDLE;
            end
            S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = r_cnt;
                if (r_cnt == LAST_SEL) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                // The last product drains into the sum.
                if (r_cnt == DRAIN_LAST) begin
                    n_state = S_SC_LO;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SC_LO: begin
                o_cmd.scale_lo = 1'b1;
                n_state        = S_SC_HI;
            end
            S_SC_HI: begin
                o_cmd.scale_hi = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/mcs_datapath.sv =====
// Datapath of the mobility correction stencil: index decomposition, the two
// grid stores, the stencil pipeline around one shared multiplier and scaling.
// Depends on mcs_pkg and mcs_ram.
module mcs_datapath #(
    parameter int unsigned GRID_SIDE     = mcs_pkg::DEF_GRID_SIDE,
    parameter int unsigned GRID_DIMS     = mcs_pkg::DEF_GRID_DIMS,
    parameter int unsigned SPECIES_COUNT = mcs_pkg::DEF_SPECIES_COUNT,
    parameter int unsigned FRACTION_BITS = mcs_pkg::DEF_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mcs_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                i_req_type,
    input  logic [mcs_pkg::SP_W-1:0]            i_species_index,
    input  logic [mcs_pkg::CELL_W-1:0]          i_cell_index,
    input  logic signed [mcs_pkg::DATA_W-1:0]   i_potential_value,
    input  logic signed [mcs_pkg::DATA_W-1:0]   i_mobility_value,
    input  mcs_pkg::t_dp_cmd                    i_cmd,
    output mcs_pkg::t_dp_status                 o_status,
    output logic                                o_strobe,
    output logic [mcs_pkg::CELL_W-1:0]          o_result_cell,
    output logic signed [mcs_pkg::DATA_W-1:0]   o_correction_value,
    output logic                                o_saturated_flag
);

    localparam int unsigned CELL_W   = mcs_pkg::CELL_W;
    localparam int unsigned DATA_W   = mcs_pkg::DATA_W;
    localparam int unsigned DIFF_W   = mcs_pkg::DIFF_W;
    localparam int unsigned ACC_W    = mcs_pkg::ACC_W;
    localparam int unsigned LO_W     = mcs_pkg::LO_W;
    localparam int unsigned MUL_W    = mcs_pkg::MUL_W;
    localparam int unsigned PROD_W   = mcs_pkg::PROD_W;
    localparam int unsigned FULL_W   = mcs_pkg::FULL_W;
    localparam int unsigned INV_W    = mcs_pkg::INV_W;
    localparam int unsigned SP_W     = mcs_pkg::SP_W;

    localparam int unsigned CELL_COUNT = (GRID_DIMS == 1) ? GRID_SIDE : GRID_SIDE * GRID_SIDE;
    localparam int unsigned DEPTH      = SPECIES_COUNT * CELL_COUNT;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned XW         = $clog2(GRID_SIDE);
    localparam int unsigned SHIFT      = 2 * FRACTION_BITS;

    // Division of a cell-wide value by GRID_SIDE: multiply by a rounded-up
    // reciprocal; exact for every numerator below 2^CELL_W.
    localparam int unsigned DIV_SHIFT = CELL_W + XW;
    localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + GRID_SIDE - 1) / GRID_SIDE;
    localparam int unsigned RECIP_W   = CELL_W + 2;
    localparam int unsigned DPROD_W   = CELL_W + RECIP_W;

    localparam logic [CELL_W-1:0] SIDE_C = CELL_W'(GRID_SIDE);
    localparam logic [XW-1:0]     X_LAST = XW'(GRID_SIDE - 1);

    function automatic logic [CELL_W-1:0] div_side(input logic [CELL_W-1:0] n);
        logic [DPROD_W-1:0] p;
        p = DPROD_W'(n) * DPROD_W'(RECIP);
        return CELL_W'(p >> DIV_SHIFT);
    endfunction

    function automatic logic [SP_W-1:0] sp_wrap(input logic [SP_W-1:0] s);
        logic [SP_W-1:0] v;
        v = s;
        for (int k = 0; k < (1 << SP_W) - 1; k++) begin
            if (32'(v) >= SPECIES_COUNT) begin
                v = v - SP_W'(SPECIES_COUNT);
            end
        end
        return v;
    endfunction

    function automatic logic [XW-1:0] wrap_up(input logic [XW-1:0] c);
        return (c == X_LAST) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [XW-1:0] wrap_dn(input logic [XW-1:0] c);
        return (c == '0) ? X_LAST : c - 1'b1;
    endfunction

    // Configuration registers.
    logic signed [DATA_W-1:0] r_ref_mob;
    logic [INV_W-1:0]         r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mob <= DATA_W'(1) << FRACTION_BITS;
            r_inv     <= INV_W'(1) << FRACTION_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcs_pkg::CFG_REF_MOB: r_ref_mob <= i_cfg_data;
                mcs_pkg::CFG_INV_DX2: r_inv     <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched transaction and decomposed cell index.
    logic                     r_req_type;
    logic [SP_W-1:0]          r_sp;
    logic [CELL_W-1:0]        r_cell;
    logic [DATA_W-1:0]        r_mu_in;
    logic [DATA_W-1:0]        r_mob_in;
    logic [CELL_W-1:0]        r_q1;
    logic [XW-1:0]            r_x;
    logic [XW-1:0]            r_y;
    logic [CELL_W-1:0]        r_cell_eff;
    logic [ADDR_W-1:0]        r_a_c, r_a_xp, r_a_xm, r_a_yp, r_a_ym;

    logic [CELL_W-1:0] q1, q2;
    logic [ADDR_W-1:0] base_sp;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [XW-1:0] yv,
                                                    input logic [XW-1:0] xv);
        return base + ADDR_W'(yv) * ADDR_W'(GRID_SIDE) + ADDR_W'(xv);
    endfunction

    assign q1      = div_side(r_cell);
    assign q2      = div_side(r_q1);
    assign base_sp = ADDR_W'(r_sp) * ADDR_W'(CELL_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req_type <= i_req_type;
            r_sp       <= sp_wrap(i_species_index);
            r_cell     <= i_cell_index;
            r_mu_in    <= i_potential_value;
            r_mob_in   <= i_mobility_value;
        end
        if (i_cmd.div1) begin
            r_q1 <= q1;
            r_x  <= XW'(r_cell - q1 * SIDE_C);
        end
        if (i_cmd.div2) begin
            if (GRID_DIMS == 2) begin
                r_y        <= XW'(r_q1 - q2 * SIDE_C);
                r_cell_eff <= r_cell - (q2 * SIDE_C) * SIDE_C;
            end else begin
                r_y        <= '0;
                r_cell_eff <= CELL_W'(r_x);
            end
        end
        if (i_cmd.nbr) begin
            r_a_c  <= cell_addr(base_sp, r_y, r_x);
            r_a_xp <= cell_addr(base_sp, r_y, wrap_up(r_x));
            r_a_xm <= cell_addr(base_sp, r_y, wrap_dn(r_x));
            r_a_yp <= cell_addr(base_sp, wrap_up(r_y), r_x);
            r_a_ym <= cell_addr(base_sp, wrap_dn(r_y), r_x);
        end
    end

    assign o_status.is_query = (r_req_type == mcs_pkg::REQ_QUERY);

    // Grid stores.
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] mu_rdata, mob_rdata;

    always_comb begin
        case (i_cmd.rd_sel)
            mcs_pkg::SEL_XP: rd_addr = r_a_xp;
            mcs_pkg::SEL_XM: rd_addr = r_a_xm;
            mcs_pkg::SEL_YP: rd_addr = r_a_yp;
            mcs_pkg::SEL_YM: rd_addr = r_a_ym;
            default:         rd_addr = r_a_c;
        endcase
    end

    mcs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mu_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_a_c),
        .i_wdata (r_mu_in),
        .i_raddr (rd_addr),
        .o_rdata (mu_rdata)
    );

    mcs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mob_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_a_c),
        .i_wdata (r_mob_in),
        .i_raddr (rd_addr),
        .o_rdata (mob_rdata)
    );

    // Stencil pipeline: read data, differences, product, accumulate.
    // Every term is (M[n] - M0) * (mu[n] - mu[c]); the minus neighbours' sign
    // folds into the potential difference.
    logic                        r_rd_vld, r_df_vld, r_pr_vld;
    logic [mcs_pkg::SEL_W-1:0]   r_rd_sel;
    logic signed [DATA_W-1:0]    r_mu_c;
    logic signed [DIFF_W-1:0]    r_dm, r_dg;
    logic signed [PROD_W-1:0]    r_prod, r_plo;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [FULL_W-1:0]    r_full;
    logic signed [MUL_W-1:0]     mul_a, mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_df_vld <= 1'b0;
            r_pr_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_df_vld <= r_rd_vld && (r_rd_sel != mcs_pkg::SEL_CENTER);
            r_pr_vld <= r_df_vld;
        end
    end

    always_comb begin
        if (i_cmd.scale_lo) begin
            mul_a = $signed({1'b0, r_acc[LO_W-1:0]});
        end else if (i_cmd.scale_hi) begin
            mul_a = MUL_W'($signed(r_acc[ACC_W-1:LO_W]));
        end else begin
            mul_a = MUL_W'(r_dm);
        end
        if (i_cmd.scale_lo || i_cmd.scale_hi) begin
            mul_b = $signed({{(MUL_W - INV_W){1'b0}}, r_inv});
        end else begin
            mul_b = MUL_W'(r_dg);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sel <= i_cmd.rd_sel;
        if (r_rd_vld) begin
            if (r_rd_sel == mcs_pkg::SEL_CENTER) begin
                r_mu_c <= mu_rdata;
            end else begin
                r_dm <= $signed({mob_rdata[DATA_W-1], mob_rdata})
                        - $signed({r_ref_mob[DATA_W-1], r_ref_mob});
                r_dg <= $signed({mu_rdata[DATA_W-1], mu_rdata})
                        - $signed({r_mu_c[DATA_W-1], r_mu_c});
            end
        end
        if (r_df_vld || i_cmd.scale_lo || i_cmd.scale_hi) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.nbr) begin
            r_acc <= '0;
        end else if (r_pr_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.scale_hi) begin
            r_plo <= r_prod;
        end
        if (i_cmd.sum) begin
            r_full <= (FULL_W'(r_prod) <<< LO_W) + FULL_W'(r_plo);
        end
    end

    // Floor shift and saturation, then the result register.
    logic signed [FULL_W-1:0] shifted;
    logic                     fits;

    assign shifted = r_full >>> SHIFT;
    assign fits    = (&shifted[FULL_W-1:DATA_W-1]) || !(|shifted[FULL_W-1:DATA_W-1]);

    logic                     r_strobe;
    logic [CELL_W-1:0]        r_out_cell;
    logic signed [DATA_W-1:0] r_out_val;
    logic                     r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_cell <= r_cell_eff;
            r_out_sat  <= !fits;
            if (fits) begin
                r_out_val <= shifted[DATA_W-1:0];
            end else if (shifted[FULL_W-1]) begin
                r_out_val <= {1'b1, {(DATA_W - 1){1'b0}}};
            end else begin
                r_out_val <= {1'b0, {(DATA_W - 1){1'b1}}};
            end
        end
    end

    assign o_strobe           = r_strobe;
    assign o_result_cell      = r_out_cell;
    assign o_correction_value = r_out_val;
    assign o_saturated_flag   = r_out_sat;

endmodule

// ===== design/mobility_correction_stencil.sv =====
// Mobility correction stencil: the next transaction is taken in the same cycle in which
// a query's result strobes; a load steps through latch, two divide steps, neighbour
// addressing and write. Query time is set by one read port per grid store (one stencil
// entry per cycle) and the single shared multiplier that also does the scaling.
// Synchronous active-low reset clears the controller, the strobe and sets both
// configuration registers to 1.0; grid contents are undefined until loaded.
//
// Depends on mcs_pkg, mcs_ram, mcs_ctrl and mcs_datapath.
//
// A transaction is accepted when start is high and busy is low. A load writes the
// potential and mobility of one cell and species. A query reads the center potential
// and, for each axis, the plus and minus neighbours with wrap-around. Each neighbour
// contributes (M[n] - M0) * (mu[n] - mu[c]); these products are summed exactly, the sum
// is multiplied by the configured reciprocal of dx squared in two partial products, and
// the result is shifted right by twice the fraction bits toward minus infinity and then
// saturated to 32 bits. The result is shown for exactly one cycle with o_strobe high;
// the receiver cannot hold it off. Configuration writes take effect at once and are
// expected only while the block is idle.
module mobility_correction_stencil #(
    parameter int unsigned GRID_SIDE     = mcs_pkg::DEF_GRID_SIDE,
    parameter int unsigned GRID_DIMS     = mcs_pkg::DEF_GRID_DIMS,
    parameter int unsigned SPECIES_COUNT = mcs_pkg::DEF_SPECIES_COUNT,
    parameter int unsigned FRACTION_BITS = mcs_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcs_pkg::DATA_W-1:0]        i_cfg_data,
    // Command side.
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [mcs_pkg::SP_W-1:0]          i_species_index,
    input  logic [mcs_pkg::CELL_W-1:0]        i_cell_index,
    input  logic signed [mcs_pkg::DATA_W-1:0] i_potential_value,
    input  logic signed [mcs_pkg::DATA_W-1:0] i_mobility_value,
    // Result side.
    output logic                              o_strobe,
    output logic [mcs_pkg::CELL_W-1:0]        o_result_cell,
    output logic signed [mcs_pkg::DATA_W-1:0] o_correction_value,
    output logic                              o_saturated_flag
);

    mcs_pkg::t_dp_cmd    cmd;
    mcs_pkg::t_dp_status status;

    // The controller sequences each transaction; it only sees start and the
    // request type of the latched transaction.
    mcs_ctrl #(
        .GRID_DIMS (GRID_DIMS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds the configuration, both grid stores, the stencil
    // pipeline and the result register.
    mcs_datapath #(
        .GRID_SIDE     (GRID_SIDE),
        .GRID_DIMS     (GRID_DIMS),
        .SPECIES_COUNT (SPECIES_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (i_req_type),
        .i_species_index    (i_species_index),
        .i_cell_index       (i_cell_index),
        .i_potential_value  (i_potential_value),
        .i_mobility_value   (i_mobility_value),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_strobe           (o_strobe),
        .o_result_cell      (o_result_cell),
        .o_correction_value (o_correction_value),
        .o_saturated_flag   (o_saturated_flag)
    );

endmodule
